// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> cons) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> cons) \
    else $error("next-cycle implication failed");

`endif

// File: hdl/cecr_pkg.sv
// Shared constants and types for the circle/edge collision block.
// No dependencies; imported by the top level and its checker.
package cecr_pkg;

  // Position fixed-point format and radius alignment
  localparam int PosFracBits = 8;
  localparam int RadUp       = (PosFracBits >= 8) ? PosFracBits - 8 : 0;
  localparam int RadDn       = (PosFracBits >= 8) ? 0 : 8 - PosFracBits;

  // Field widths
  localparam int PosW     = 24;
  localparam int RadInW   = 16;
  localparam int RadW     = RadInW + RadUp;
  localparam int DirW     = 16;
  localparam int DirFrac  = 14;
  localparam int LenW     = 23;
  localparam int ElasW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Datapath widths
  localparam int NrmW   = DirW + 1;
  localparam int EcW    = ((PosW > RadW) ? PosW : RadW) + 2;
  localparam int PdW    = NrmW + EcW;
  localparam int DnW    = PdW + 1;
  localparam int VpW    = PosW + NrmW;
  localparam int VnW    = VpW + 1;
  localparam int KW     = 18;
  localparam int VnLoW  = VnW / 2;
  localparam int VnHiW  = VnW - VnLoW;
  localparam int PkW    = VnW + KW + 1;
  localparam int MShift = 16;
  localparam int MW     = PkW - MShift;
  localparam int MLoW   = MW / 2;
  localparam int MHiW   = MW - MLoW;
  localparam int QpW    = NrmW + MHiW;
  localparam int QW     = NrmW + MW;
  localparam int IShift = 28;
  localparam int ImpW   = QW - IShift;
  localparam int NvW    = ImpW + 1;

  // Restitution base: (1 + e) = K / 2^16
  localparam int KBase = 65536;

  // Reset values of the edge registers
  localparam logic [DirW-1:0]  DirXReset = 16'd16384;
  localparam logic [ElasW-1:0] ElasReset = 16'd29491;

  // Register stages from the request register to the result register
  localparam int PipeDepth = 10;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX     = 3'd0,
    CfgStartY     = 3'd1,
    CfgDirX       = 3'd2,
    CfgDirY       = 3'd3,
    CfgLength     = 3'd4,
    CfgElasticity = 3'd5
  } cfg_reg_e;

endpackage

// File: hdl/circle_edge_collision_response.sv
// Circle against edge: contact tests and restitution-scaled reflection.
// Depends on cecr_pkg.
// A request taken at a clock edge passes through ten register stages and
// shows its result on the result ports with done_o high.
// Throughput: one request per cycle; busy_o is never raised, the pipeline
// has no stall. Reset clears the stage valid bits and loads edge defaults.
module circle_edge_collision_response (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cecr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cecr_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic signed [cecr_pkg::PosW-1:0]    ball_x_i,
  input  logic signed [cecr_pkg::PosW-1:0]    ball_y_i,
  input  logic [cecr_pkg::RadInW-1:0]         ball_radius_i,
  input  logic signed [cecr_pkg::PosW-1:0]    vel_x_i,
  input  logic signed [cecr_pkg::PosW-1:0]    vel_y_i,
  input  logic [cecr_pkg::ElasW-1:0]          ball_elasticity_i,
  output logic                                line_contact_o,
  output logic                                segment_contact_o,
  output logic signed [cecr_pkg::PosW-1:0]    new_vel_x_o,
  output logic signed [cecr_pkg::PosW-1:0]    new_vel_y_o,
  output logic                                moving_inward_o,
  output logic                                done_o
);
  import cecr_pkg::*;

  // Edge registers
  logic signed [PosW-1:0] start_x_q, start_y_q;
  logic signed [DirW-1:0] dir_x_q, dir_y_q;
  logic [LenW-1:0]        len_q;
  logic [ElasW-1:0]       elas_q;

  // Stage valid bits
  logic [PipeDepth-1:0] vld_q;
  logic                 accept;

  // Derived edge vectors: inner normal n = (-uy, ux)
  logic signed [NrmW-1:0] nrm_x, nrm_y, dir_ye;

  // Stage 1: centre offset from edge start
  logic [RadW-1:0]        rad_d;
  logic signed [EcW-1:0]  ecx_d, ecy_d;
  logic [KW-1:0]          k_d;
  logic signed [EcW-1:0]  s1_ecx_q, s1_ecy_q;
  logic [RadW-1:0]        s1_rad_q;
  logic [KW-1:0]          s1_k_q;
  logic signed [PosW-1:0] s1_vx_q, s1_vy_q;

  // Stage 2: dot-product terms
  logic signed [PdW-1:0]  s2_pnx_q, s2_pny_q, s2_pux_q, s2_puy_q;
  logic signed [VpW-1:0]  s2_pvx_q, s2_pvy_q;
  logic [RadW-1:0]        s2_rad_q;
  logic [KW-1:0]          s2_k_q;
  logic signed [PosW-1:0] s2_vx_q, s2_vy_q;

  // Stage 3: dot products
  logic signed [DnW-1:0]  s3_dn_q, s3_du_q;
  logic signed [VnW-1:0]  s3_vn_q;
  logic [RadW-1:0]        s3_rad_q;
  logic [KW-1:0]          s3_k_q;
  logic signed [PosW-1:0] s3_vx_q, s3_vy_q;

  // Stage 4: contact decisions and normal speed times K
  logic signed [DnW-1:0]        rlim, llim;
  logic                         line_d, seg_d, inward_d;
  logic [VnLoW-1:0]             vn_lo;
  logic signed [VnHiW-1:0]      vn_hi;
  logic signed [KW:0]           k_s;
  logic [VnLoW+KW-1:0]          s4_pkl_q;
  logic signed [VnHiW+KW:0]     s4_pkh_q;
  logic                         s4_line_q, s4_seg_q, s4_inw_q;
  logic signed [PosW-1:0]       s4_vx_q, s4_vy_q;

  // Stage 5: negated product
  logic signed [PkW-1:0]  s5_x_q;
  logic                   s5_line_q, s5_seg_q, s5_inw_q;
  logic signed [PosW-1:0] s5_vx_q, s5_vy_q;

  // Stage 6: rounded impulse magnitude m
  logic signed [PkW-1:0]  x_rnd;
  logic signed [MW-1:0]   s6_m_q;
  logic                   s6_line_q, s6_seg_q, s6_inw_q;
  logic signed [PosW-1:0] s6_vx_q, s6_vy_q;

  // Stage 7: n * m partial products
  logic [MLoW-1:0]           m_lo;
  logic signed [MHiW-1:0]    m_hi;
  logic signed [MLoW:0]      m_lo_s;
  logic signed [NrmW+MLoW:0] s7_qxl_q, s7_qyl_q;
  logic signed [QpW-1:0]     s7_qxh_q, s7_qyh_q;
  logic                      s7_line_q, s7_seg_q, s7_inw_q;
  logic signed [PosW-1:0]    s7_vx_q, s7_vy_q;

  // Stage 8: n * m
  logic signed [QW-1:0]   s8_qx_q, s8_qy_q;
  logic                   s8_line_q, s8_seg_q, s8_inw_q;
  logic signed [PosW-1:0] s8_vx_q, s8_vy_q;

  // Stage 9: rounded impulse
  logic signed [QW-1:0]   qx_rnd, qy_rnd;
  logic signed [ImpW-1:0] s9_ix_q, s9_iy_q;
  logic                   s9_line_q, s9_seg_q, s9_inw_q;
  logic signed [PosW-1:0] s9_vx_q, s9_vy_q;

  // Stage 10: saturated new velocity
  logic signed [NvW-1:0]  sum_x, sum_y;
  logic signed [PosW-1:0] sat_x, sat_y, nvx_d, nvy_d;
  logic                   line_q, seg_q, inw_q;
  logic signed [PosW-1:0] nvx_q, nvy_q;

  // Handshakes: never busy, configuration always taken
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Hold edge registers, write on a configuration request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      dir_x_q   <= DirXReset;
      dir_y_q   <= '0;
      len_q     <= '0;
      elas_q    <= ElasReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgStartX:     start_x_q <= cfg_wdata_i[PosW-1:0];
        CfgStartY:     start_y_q <= cfg_wdata_i[PosW-1:0];
        CfgDirX:       dir_x_q   <= cfg_wdata_i[DirW-1:0];
        CfgDirY:       dir_y_q   <= cfg_wdata_i[DirW-1:0];
        CfgLength:     len_q     <= cfg_wdata_i[LenW-1:0];
        CfgElasticity: elas_q    <= cfg_wdata_i[ElasW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], accept};
    end
  end

  assign nrm_x  = -(NrmW'(dir_y_q));
  assign nrm_y  = NrmW'(dir_x_q);
  assign dir_ye = NrmW'(dir_y_q);

  // Stage 1 logic: centre minus edge start, restitution sum
  always_comb begin
    rad_d = (RadW'(ball_radius_i) << RadUp) >> RadDn;
    ecx_d = EcW'(ball_x_i) + EcW'(rad_d) - EcW'(start_x_q);
    ecy_d = EcW'(ball_y_i) + EcW'(rad_d) - EcW'(start_y_q);
    k_d   = KW'(KBase) + KW'(elas_q) + KW'(ball_elasticity_i);
  end

  // Stage 4 logic: contact limits and K split product operands
  always_comb begin
    rlim     = DnW'({s3_rad_q, {DirFrac{1'b0}}});
    llim     = DnW'({len_q, {DirFrac{1'b0}}});
    line_d   = (s3_dn_q <= rlim) && (s3_dn_q >= -rlim);
    seg_d    = line_d && !s3_dn_q[DnW-1] && !s3_du_q[DnW-1] && (s3_du_q != '0)
               && (s3_du_q < llim);
    inward_d = s3_vn_q[VnW-1] || (s3_vn_q == '0);
    vn_lo    = s3_vn_q[VnLoW-1:0];
    vn_hi    = s3_vn_q[VnW-1:VnLoW];
    k_s      = {1'b0, s3_k_q};
  end

  // Stage 6 logic: round half away from zero over MShift bits
  assign x_rnd = s5_x_q + (s5_x_q[PkW-1] ? PkW'((1 << (MShift - 1)) - 1)
                                         : PkW'(1 << (MShift - 1)));

  // Stage 7 logic: split m into halves
  assign m_lo   = s6_m_q[MLoW-1:0];
  assign m_hi   = s6_m_q[MW-1:MLoW];
  assign m_lo_s = {1'b0, m_lo};

  // Stage 9 logic: round half away from zero over IShift bits
  assign qx_rnd = s8_qx_q + (s8_qx_q[QW-1] ? QW'((1 << (IShift - 1)) - 1)
                                           : QW'(1 << (IShift - 1)));
  assign qy_rnd = s8_qy_q + (s8_qy_q[QW-1] ? QW'((1 << (IShift - 1)) - 1)
                                           : QW'(1 << (IShift - 1)));

  // Stage 10 logic: add impulse, saturate, drop it when moving away
  always_comb begin
    sum_x = NvW'(s9_vx_q) + NvW'(s9_ix_q);
    sum_y = NvW'(s9_vy_q) + NvW'(s9_iy_q);
    if ((&sum_x[NvW-1:PosW-1]) || !(|sum_x[NvW-1:PosW-1])) begin
      sat_x = sum_x[PosW-1:0];
    end else begin
      sat_x = sum_x[NvW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    if ((&sum_y[NvW-1:PosW-1]) || !(|sum_y[NvW-1:PosW-1])) begin
      sat_y = sum_y[PosW-1:0];
    end else begin
      sat_y = sum_y[NvW-1] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end
    nvx_d = s9_inw_q ? sat_x : s9_vx_q;
    nvy_d = s9_inw_q ? sat_y : s9_vy_q;
  end

  // Payload pipeline; the valid bits qualify every stage
  always_ff @(posedge clk_i) begin
    // stage 1
    s1_ecx_q <= ecx_d;
    s1_ecy_q <= ecy_d;
    s1_rad_q <= rad_d;
    s1_k_q   <= k_d;
    s1_vx_q  <= vel_x_i;
    s1_vy_q  <= vel_y_i;
    // stage 2
    s2_pnx_q <= nrm_x * s1_ecx_q;
    s2_pny_q <= nrm_y * s1_ecy_q;
    s2_pux_q <= nrm_y * s1_ecx_q;
    s2_puy_q <= dir_ye * s1_ecy_q;
    s2_pvx_q <= s1_vx_q * nrm_x;
    s2_pvy_q <= s1_vy_q * nrm_y;
    s2_rad_q <= s1_rad_q;
    s2_k_q   <= s1_k_q;
    s2_vx_q  <= s1_vx_q;
    s2_vy_q  <= s1_vy_q;
    // stage 3
    s3_dn_q  <= DnW'(s2_pnx_q) + DnW'(s2_pny_q);
    s3_du_q  <= DnW'(s2_pux_q) + DnW'(s2_puy_q);
    s3_vn_q  <= VnW'(s2_pvx_q) + VnW'(s2_pvy_q);
    s3_rad_q <= s2_rad_q;
    s3_k_q   <= s2_k_q;
    s3_vx_q  <= s2_vx_q;
    s3_vy_q  <= s2_vy_q;
    // stage 4
    s4_pkl_q  <= vn_lo * s3_k_q;
    s4_pkh_q  <= vn_hi * k_s;
    s4_line_q <= line_d;
    s4_seg_q  <= seg_d;
    s4_inw_q  <= inward_d;
    s4_vx_q   <= s3_vx_q;
    s4_vy_q   <= s3_vy_q;
    // stage 5
    s5_x_q    <= -(PkW'(s4_pkh_q) <<< VnLoW) - PkW'(s4_pkl_q);
    s5_line_q <= s4_line_q;
    s5_seg_q  <= s4_seg_q;
    s5_inw_q  <= s4_inw_q;
    s5_vx_q   <= s4_vx_q;
    s5_vy_q   <= s4_vy_q;
    // stage 6
    s6_m_q    <= x_rnd[PkW-1:MShift];
    s6_line_q <= s5_line_q;
    s6_seg_q  <= s5_seg_q;
    s6_inw_q  <= s5_inw_q;
    s6_vx_q   <= s5_vx_q;
    s6_vy_q   <= s5_vy_q;
    // stage 7
    s7_qxl_q  <= nrm_x * m_lo_s;
    s7_qyl_q  <= nrm_y * m_lo_s;
    s7_qxh_q  <= nrm_x * m_hi;
    s7_qyh_q  <= nrm_y * m_hi;
    s7_line_q <= s6_line_q;
    s7_seg_q  <= s6_seg_q;
    s7_inw_q  <= s6_inw_q;
    s7_vx_q   <= s6_vx_q;
    s7_vy_q   <= s6_vy_q;
    // stage 8
    s8_qx_q   <= (QW'(s7_qxh_q) <<< MLoW) + QW'(s7_qxl_q);
    s8_qy_q   <= (QW'(s7_qyh_q) <<< MLoW) + QW'(s7_qyl_q);
    s8_line_q <= s7_line_q;
    s8_seg_q  <= s7_seg_q;
    s8_inw_q  <= s7_inw_q;
    s8_vx_q   <= s7_vx_q;
    s8_vy_q   <= s7_vy_q;
    // stage 9
    s9_ix_q   <= qx_rnd[QW-1:IShift];
    s9_iy_q   <= qy_rnd[QW-1:IShift];
    s9_line_q <= s8_line_q;
    s9_seg_q  <= s8_seg_q;
    s9_inw_q  <= s8_inw_q;
    s9_vx_q   <= s8_vx_q;
    s9_vy_q   <= s8_vy_q;
    // stage 10: result register
    line_q <= s9_line_q;
    seg_q  <= s9_seg_q;
    inw_q  <= s9_inw_q;
    nvx_q  <= nvx_d;
    nvy_q  <= nvy_d;
  end

  // Drive the result ports
  assign line_contact_o    = line_q;
  assign segment_contact_o = seg_q;
  assign moving_inward_o   = inw_q;
  assign new_vel_x_o       = nvx_q;
  assign new_vel_y_o       = nvy_q;
  assign done_o            = vld_q[PipeDepth-1];

endmodule

// File: hdl/cecr_checker.sv
// Port-level checks for the circle/edge collision block, bound to its top.
// Depends on cecr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cecr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic signed [cecr_pkg::PosW-1:0] vel_x_i,
  input logic signed [cecr_pkg::PosW-1:0] vel_y_i,
  input logic signed [cecr_pkg::PosW-1:0] new_vel_x_o,
  input logic signed [cecr_pkg::PosW-1:0] new_vel_y_o,
  input logic                             line_contact_o,
  input logic                             segment_contact_o,
  input logic                             moving_inward_o
);
  import cecr_pkg::*;

  // Velocity pairs and the moving-away result flag
  logic [2*PosW-1:0] vel_in, vel_out;
  logic              away_res;

  assign vel_in   = {vel_x_i, vel_y_i};
  assign vel_out  = {new_vel_x_o, new_vel_y_o};
  assign away_res = done_o && !moving_inward_o;

  // Every request yields a result after the fixed latency
  `ASSERT_NEXT(a_req_to_done, clk_i, rst_ni, start_i && !busy_o, ##(PipeDepth-1) done_o)

  // No result without a request the fixed latency earlier
  `ASSERT_IMPL(a_done_has_req, clk_i, rst_ni, done_o, $past(start_i && !busy_o, PipeDepth))

  // Segment contact implies line contact
  `ASSERT_IMPL(a_seg_implies_line, clk_i, rst_ni, done_o && segment_contact_o, line_contact_o)

  // Moving away leaves the velocity untouched
  `ASSERT_IMPL(a_away_keeps_vel, clk_i, rst_ni, away_res, vel_out == $past(vel_in, PipeDepth))

endmodule

bind circle_edge_collision_response cecr_checker u_cecr_checker (.*);

// File: test/tb.sv
// Testbench for circle_edge_collision_response: contact flags and reflected velocity.
// Depends on cecr_pkg and the block's RTL. A scoreboard class predicts each request's
// result and checks it in order; plain tasks drive requests and edge register writes.
`timescale 1ns / 100ps

import cecr_pkg::*;

localparam longint FixMax = (longint'(1) <<< (PosW - 1)) - 1;
localparam longint FixMin = -(longint'(1) <<< (PosW - 1));

typedef struct packed {
  logic signed [PosW-1:0] x;
  logic signed [PosW-1:0] y;
  logic [RadInW-1:0]      radius;
  logic signed [PosW-1:0] vx;
  logic signed [PosW-1:0] vy;
  logic [ElasW-1:0]       elas;
} ball_t;

typedef struct packed {
  logic signed [PosW-1:0] start_x;
  logic signed [PosW-1:0] start_y;
  logic signed [DirW-1:0] dir_x;
  logic signed [DirW-1:0] dir_y;
  logic [LenW-1:0]        length;
  logic [ElasW-1:0]       elas;
} wall_t;

typedef struct packed {
  logic                   line;
  logic                   seg;
  logic signed [PosW-1:0] nvx;
  logic signed [PosW-1:0] nvy;
  logic                   inward;
} result_t;

// Predict the bounce of each accepted ball and match results in order
class bounce_ledger;
  wall_t   wall;
  result_t pending_bounces[$];
  int      errors;

  function new();
    wall = '0;
    wall.dir_x = DirXReset;
    wall.elas = ElasReset;
    errors = 0;
  endfunction

  // Mirror one edge register write, keeping only the register's own bits
  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgStartX:     wall.start_x = data[PosW-1:0];
      CfgStartY:     wall.start_y = data[PosW-1:0];
      CfgDirX:       wall.dir_x = data[DirW-1:0];
      CfgDirY:       wall.dir_y = data[DirW-1:0];
      CfgLength:     wall.length = data[LenW-1:0];
      CfgElasticity: wall.elas = data[ElasW-1:0];
      default: ;
    endcase
  endfunction

  // Divide by 2^sh, rounding to nearest with ties away from zero
  function longint round_shift(longint v, int sh);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -r : r;
  endfunction

  function longint clamp_fix(longint v);
    if (v > FixMax) return FixMax;
    if (v < FixMin) return FixMin;
    return v;
  endfunction

  function result_t predict_bounce(ball_t b);
    result_t res;
    longint rad, ux, uy, nx, ny, ecx, ecy, dn, du, adn, vx, vy, vn, k, m;
    rad = (longint'(b.radius) << RadUp) >> RadDn;
    ux = longint'(wall.dir_x);
    uy = longint'(wall.dir_y);
    nx = -uy;
    ny = ux;
    ecx = longint'(b.x) + rad - longint'(wall.start_x);
    ecy = longint'(b.y) + rad - longint'(wall.start_y);
    dn = nx * ecx + ny * ecy;
    du = ux * ecx + uy * ecy;
    adn = (dn < 0) ? -dn : dn;
    res.line = (adn <= (rad << DirFrac));
    res.seg = res.line && dn >= 0 && du > 0 && du < (longint'(wall.length) << DirFrac);
    vx = longint'(b.vx);
    vy = longint'(b.vy);
    vn = vx * nx + vy * ny;
    res.inward = (vn <= 0);
    // Apply the impulse only when not moving away along the normal
    if (res.inward) begin
      k = longint'(KBase) + longint'(wall.elas) + longint'(b.elas);
      m = round_shift(-(vn * k), MShift);
      vx = clamp_fix(vx + round_shift(nx * m, IShift));
      vy = clamp_fix(vy + round_shift(ny * m, IShift));
    end
    res.nvx = PosW'(vx);
    res.nvy = PosW'(vy);
    return res;
  endfunction

  function void note_ball(ball_t b);
    pending_bounces.push_back(predict_bounce(b));
  endfunction

  function void check_bounce(result_t got);
    result_t exp_r;
    if (pending_bounces.size() == 0) begin
      $error("result with no request pending");
      errors++;
      return;
    end
    exp_r = pending_bounces.pop_front();
    if (got.line !== exp_r.line) begin
      $error("line_contact: expected %0d, got %0d", exp_r.line, got.line);
      errors++;
    end
    if (got.seg !== exp_r.seg) begin
      $error("segment_contact: expected %0d, got %0d", exp_r.seg, got.seg);
      errors++;
    end
    if (got.nvx !== exp_r.nvx) begin
      $error("new_vel_x: expected %0d, got %0d", exp_r.nvx, got.nvx);
      errors++;
    end
    if (got.nvy !== exp_r.nvy) begin
      $error("new_vel_y: expected %0d, got %0d", exp_r.nvy, got.nvy);
      errors++;
    end
    if (got.inward !== exp_r.inward) begin
      $error("moving_inward: expected %0d, got %0d", exp_r.inward, got.inward);
      errors++;
    end
  endfunction

  function int pending();
    return pending_bounces.size();
  endfunction
endclass

module tb;
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_wdata_i;
  logic signed [PosW-1:0] ball_x_i;
  logic signed [PosW-1:0] ball_y_i;
  logic [RadInW-1:0]      ball_radius_i;
  logic signed [PosW-1:0] vel_x_i;
  logic signed [PosW-1:0] vel_y_i;
  logic [ElasW-1:0]       ball_elasticity_i;
  logic                   line_contact_o;
  logic                   segment_contact_o;
  logic signed [PosW-1:0] new_vel_x_o;
  logic signed [PosW-1:0] new_vel_y_o;
  logic                   moving_inward_o;
  logic                   done_o;

  bounce_ledger ledger = new();
  result_t      seen;
  int           balls_sent = 0;

  circle_edge_collision_response dut (.*);

  always #5 clk_i = ~clk_i;

  // Hand every result to the ledger in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen = '{line_contact_o, segment_contact_o, new_vel_x_o, new_vel_y_o, moving_inward_o};
      ledger.check_bounce(seen);
    end
  end

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [PosW-1:0] pick_extreme_fix();
    case ($urandom_range(3))
      0: return PosW'(FixMin);
      1: return PosW'(FixMax);
      2: return '0;
      default: return PosW'($urandom);
    endcase
  endfunction

  function automatic logic [ElasW-1:0] pick_elasticity();
    case ($urandom_range(4))
      0: return '0;
      1: return ElasW'(32768);
      2: return '1;
      default: return ElasW'($urandom);
    endcase
  endfunction

  // Place a ball around the configured edge: near the line, its ends and its radius bound
  function automatic ball_t ball_near_wall();
    ball_t  b;
    longint ux, uy, t, d, r_al, c;
    int     r;
    ux = longint'(ledger.wall.dir_x);
    uy = longint'(ledger.wall.dir_y);
    r = ($urandom_range(7) == 0) ? int'($urandom_range(65535)) : int'($urandom_range(4096));
    r_al = (longint'(r) << RadUp) >> RadDn;
    case ($urandom_range(5))
      0: t = 0;
      1: t = longint'(ledger.wall.length);
      2: t = longint'(rand_span(3));
      3: t = longint'(ledger.wall.length) + longint'(rand_span(3));
      default: t = longint'($urandom_range(int'(ledger.wall.length)));
    endcase
    case ($urandom_range(3))
      0: d = r_al;
      1: d = -r_al;
      2: d = ($urandom_range(1) == 1) ? r_al + 1 : -r_al - 1;
      default: d = longint'(rand_span(r + 64));
    endcase
    b.x = PosW'(longint'(ledger.wall.start_x) + ((t * ux - d * uy) >>> DirFrac) - r_al);
    b.y = PosW'(longint'(ledger.wall.start_y) + ((t * uy + d * ux) >>> DirFrac) - r_al);
    b.radius = RadInW'(r);
    case ($urandom_range(5))
      0: begin
        // Parallel to the edge: zero normal speed
        c = longint'(rand_span(255));
        b.vx = PosW'(c * ux);
        b.vy = PosW'(c * uy);
      end
      1: begin
        b.vx = PosW'($urandom);
        b.vy = PosW'($urandom);
      end
      2: begin
        b.vx = pick_extreme_fix();
        b.vy = pick_extreme_fix();
      end
      default: begin
        b.vx = PosW'(rand_span(65536));
        b.vy = PosW'(rand_span(65536));
      end
    endcase
    b.elas = pick_elasticity();
    return b;
  endfunction

  function automatic ball_t ball_anywhere();
    ball_t b;
    if ($urandom_range(2) == 0) begin
      b.x = pick_extreme_fix();
      b.y = pick_extreme_fix();
      b.radius = ($urandom_range(1) == 1) ? '1 : '0;
      b.vx = pick_extreme_fix();
      b.vy = pick_extreme_fix();
      b.elas = pick_elasticity();
    end else begin
      b.x = PosW'($urandom);
      b.y = PosW'($urandom);
      b.radius = RadInW'($urandom);
      b.vx = PosW'($urandom);
      b.vy = PosW'($urandom);
      b.elas = ElasW'($urandom);
    end
    return b;
  endfunction

  function automatic wall_t make_wall(longint sx, longint sy, longint dx, longint dy,
                                      longint len, longint el);
    wall_t w;
    w.start_x = PosW'(sx);
    w.start_y = PosW'(sy);
    w.dir_x = DirW'(dx);
    w.dir_y = DirW'(dy);
    w.length = LenW'(len);
    w.elas = ElasW'(el);
    return w;
  endfunction

  // Send one ball request, idling first at the current sender rate
  task automatic send_ball(ball_t b);
    int idle_pct;
    idle_pct = (balls_sent < 233) ? 25 : (balls_sent < 466) ? 67 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      ball_x_i <= PosW'($urandom);
      vel_y_i <= PosW'($urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    ball_x_i <= b.x;
    ball_y_i <= b.y;
    ball_radius_i <= b.radius;
    vel_x_i <= b.vx;
    vel_y_i <= b.vy;
    ball_elasticity_i <= b.elas;
    do @(posedge clk_i); while (busy_o);
    ledger.note_ball(b);
    balls_sent++;
  endtask

  // Ball given by its centre, the way the contact tests see it
  task automatic send_centered(longint cx, longint cy, int r, longint vx, longint vy, int el);
    ball_t b;
    b.x = PosW'(cx - longint'(r));
    b.y = PosW'(cy - longint'(r));
    b.radius = RadInW'(r);
    b.vx = PosW'(vx);
    b.vy = PosW'(vy);
    b.elas = ElasW'(el);
    send_ball(b);
  endtask

  task automatic send_random_balls(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) send_ball(ball_near_wall());
      else send_ball(ball_anywhere());
    end
  endtask

  task automatic write_wall_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(idx, data);
  endtask

  // Drain the pipeline, then load all edge registers; junk fills unused upper bits
  task automatic program_wall(wall_t w);
    start_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    write_wall_reg(CfgStartX, CfgDataW'(w.start_x));
    write_wall_reg(CfgStartY, CfgDataW'(w.start_y));
    write_wall_reg(CfgDirX, {8'($urandom), w.dir_x});
    write_wall_reg(CfgDirY, {8'($urandom), w.dir_y});
    write_wall_reg(CfgLength, {1'($urandom), w.length});
    write_wall_reg(CfgElasticity, {8'($urandom), w.elas});
    // Writes to unused indexes must change nothing
    write_wall_reg(CfgIdxW'(CfgElasticity) + 3'd1, CfgDataW'($urandom));
    write_wall_reg(CfgIdxW'(CfgElasticity) + 3'd2, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    real theta;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgStartX;
    cfg_wdata_i = '0;
    ball_x_i = '0;
    ball_y_i = '0;
    ball_radius_i = '0;
    vel_x_i = '0;
    vel_y_i = '0;
    ball_elasticity_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset edge: zero length, so segment contact never holds
    send_centered(0, 0, 256, 100, -100, 16384);
    send_centered(500, -256, 256, 0, 300, 0);
    send_random_balls(38);

    // Horizontal edge from the origin, 100.0 long, inner normal +y
    program_wall(make_wall(0, 0, 16384, 0, 25600, ElasReset));
    send_centered(1000, 0, 256, 0, -512, 16384);
    send_centered(0, 0, 256, 100, -100, 16384);
    send_centered(25600, 0, 256, 100, -100, 16384);
    send_centered(25599, 256, 256, -7, -9, 16384);
    send_centered(1000, 257, 256, 0, -512, 16384);
    send_centered(1000, -256, 256, 0, -512, 16384);
    send_centered(1000, 0, 256, 5, 100, 16384);
    send_centered(1000, 0, 256, 300, 0, 16384);
    send_centered(1000, 0, 256, 0, FixMin, 65535);
    send_centered(1000, 0, 256, FixMin, FixMin, 32768);
    send_centered(1000, 0, 256, FixMax, -1, 0);
    send_centered(1000, 0, 0, 7, -3, 16384);
    send_centered(1000, 0, 65535, -3, -300, 65535);
    send_centered(FixMax, FixMin, 0, FixMax, FixMax, 32768);
    send_centered(FixMin, FixMax, 0, FixMin, FixMax, 0);
    send_centered(-5000, 3, 256, 1, -1, 32768);
    send_random_balls(40);

    // Walk through edge settings, extremes among them
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: program_wall(make_wall(rand_span(1 << 20), rand_span(1 << 20), 0, 16384,
                                  1 << 20, 0));
        1: program_wall(make_wall(rand_span(1 << 20), rand_span(1 << 20), 11585, 11585,
                                  1 << 16, 32768));
        2: program_wall(make_wall(FixMin, FixMax, -16384, 0, (1 << LenW) - 1, 65535));
        3: program_wall(make_wall(FixMax, FixMin, 0, -16384, 1, 32768));
        4: begin
          theta = real'($urandom_range(6283)) / 1000.0;
          program_wall(make_wall(rand_span(1 << 22), rand_span(1 << 22),
                                 longint'($rtoi(16384.0 * $cos(theta))),
                                 longint'($rtoi(16384.0 * $sin(theta))),
                                 $urandom_range(1 << 22), pick_elasticity()));
        end
        5: program_wall(make_wall($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom));
        default: program_wall(make_wall(rand_span(1 << 20), rand_span(1 << 20), 0, 0,
                                        $urandom_range(1 << 20), $urandom));
      endcase
      send_random_balls(90);
    end

    // Drain, then allow stray results to show up
    start_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
